[hw/rtl/crwf_pkg.sv]
// types and constants shared by the count-rate window filter
package crwf_pkg;

    // default widths of the window state
    localparam int INDEX_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF = 16;

    // field widths of the beats and registers
    localparam int TIME_W    = 64;
    localparam int TICKS_W   = 32;
    localparam int LIMIT_W   = 16;
    localparam int OUT_IDX_W = 32;
    localparam int OUT_CNT_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT       = 2'd2;

    // one input beat
    typedef struct packed {
        logic [TIME_W-1:0] macro_time;
        logic              is_last;
    } crwf_in_t;

    // one result beat
    typedef struct packed {
        logic [OUT_IDX_W-1:0] event_index;
        logic [OUT_CNT_W-1:0] photon_count;
        logic                 mask_bit;
    } crwf_out_t;

endpackage

[hw/rtl/count_rate_window_filter_core.sv]
// count-rate window filter: cuts timestamps into windows and emits count and mask
//
//  channel | ports                                  | direction | beat
//  --------+----------------------------------------+-----------+--------------------------
//  input   | s_valid, s_ready, s_data               | in        | macro_time, is_last
//  result  | m_valid, m_ready, m_data               | out       | event_index, count, mask
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in     | register index and value
//
//  one beat per cycle unless a closing beat waits on a held result; a beat is held in the
//  input register, and its result is registered in the result register that drives m_data
//  the 64-bit subtract and compare against the window length sets the cycle time
//  synchronous active-low reset clears the window state, valids and configuration registers to defaults
//  a stalled result holds the input register only when that beat itself closes a window
module count_rate_window_filter_core
    import crwf_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input beats
    input  logic                 s_valid,
    output logic                 s_ready,
    input  crwf_in_t             s_data,
    // result beats
    output logic                 m_valid,
    input  logic                 m_ready,
    output crwf_out_t            m_data,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

    // configuration registers
    logic [TICKS_W-1:0]    ticks_reg;
    logic [LIMIT_W-1:0]    limit_reg;
    logic                  invert_reg;

    // input register
    logic                  in_valid_reg;
    crwf_in_t              in_data_reg;

    // window state
    logic                  open_reg, open_next;
    logic [TIME_W-1:0]     start_time_reg, start_time_next;
    logic [INDEX_BITS-1:0] start_idx_reg, start_idx_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [INDEX_BITS-1:0] next_idx_reg, next_idx_next;

    // result register
    logic                  out_valid_reg;
    crwf_out_t             out_data_reg, out_data_next;

    // datapath
    logic [TICKS_W-1:0]    win_len;
    logic [TIME_W-1:0]     diff;
    logic                  emit;
    logic                  advance;
    logic [CMP_W-1:0]      cnt_ext, lim_ext;
    logic                  mask;

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg  <= TICKS_W'(1);
            limit_reg  <= '0;
            invert_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_WINDOW_TICKS: ticks_reg  <= cfg_data[TICKS_W-1:0];
                CFG_COUNT_LIMIT:  limit_reg  <= cfg_data[LIMIT_W-1:0];
                CFG_INVERT:       invert_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // window close test and mask decision
    always_comb begin
        win_len = (ticks_reg == '0) ? TICKS_W'(1) : ticks_reg;
        diff    = in_data_reg.macro_time - start_time_reg;
        emit    = in_valid_reg && open_reg &&
                  (in_data_reg.is_last || (diff >= TIME_W'(win_len)));
        cnt_ext = CMP_W'(cnt_reg);
        lim_ext = CMP_W'(limit_reg);
        mask    = invert_reg ? (cnt_ext >= lim_ext) : (cnt_ext < lim_ext);
    end

    // a beat moves on unless its result finds the output still full
    assign advance = in_valid_reg && (!emit || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // next window state
    always_comb begin
        open_next       = open_reg;
        start_time_next = start_time_reg;
        start_idx_next  = start_idx_reg;
        cnt_next        = cnt_reg;
        next_idx_next   = next_idx_reg;
        out_data_next.event_index  = OUT_IDX_W'(start_idx_reg);
        out_data_next.photon_count = OUT_CNT_W'(cnt_reg);
        out_data_next.mask_bit     = mask;

        if (in_data_reg.is_last) begin
            open_next     = 1'b0;
            next_idx_next = '0;
        end else begin
            next_idx_next = next_idx_reg + INDEX_BITS'(1);
            if (!open_reg || emit) begin
                // open a fresh window at this beat
                open_next       = 1'b1;
                start_time_next = in_data_reg.macro_time;
                start_idx_next  = next_idx_reg;
                cnt_next        = COUNT_BITS'(1);
            end else if (!(&cnt_reg)) begin
                cnt_next = cnt_reg + COUNT_BITS'(1);
            end
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // window state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg       <= 1'b0;
            start_time_reg <= '0;
            start_idx_reg  <= '0;
            cnt_reg        <= '0;
            next_idx_reg   <= '0;
        end else if (advance) begin
            open_reg       <= open_next;
            start_time_reg <= start_time_next;
            start_idx_reg  <= start_idx_next;
            cnt_reg        <= cnt_next;
            next_idx_reg   <= next_idx_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef SYNTHESIS
    // a last beat ends the record and restarts the index
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_data_reg.is_last) |=> (!open_reg && next_idx_reg == '0))
        else $error("window state not cleared after last beat");

    // an open window has counted at least its opening beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg |-> (cnt_reg != '0))
        else $error("open window with zero count");

    // input stalls only behind a closing beat and a held result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && emit && out_valid_reg && !m_ready))
        else $error("input stalled without cause");

    // a result held by the sink keeps its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("held result changed");
`endif

endmodule
